// ----- rtl/mxe_pkg.sv -----
// mxe_pkg: shared types and constants for the MIPS64 integer execute block.
// No dependencies.
package mxe_pkg;

   typedef struct packed {
      logic [31:0] instr;
      logic [63:0] pc;
   } req_type;

   typedef struct packed {
      logic        wb_enable;
      logic [4:0]  wb_index;
      logic [63:0] wb_value;
      logic        branch_taken;
      logic [63:0] branch_target;
      logic        annul_slot;
      logic        unimplemented;
   } rsp_type;

   // main opcodes
   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_REGIMM  = 6'd1;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_BLEZ    = 6'd6;
   localparam logic [5:0] OP_BGTZ    = 6'd7;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_SLTI    = 6'd10;
   localparam logic [5:0] OP_SLTIU   = 6'd11;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_XORI    = 6'd14;
   localparam logic [5:0] OP_LUI     = 6'd15;
   localparam logic [5:0] OP_BEQL    = 6'd20;
   localparam logic [5:0] OP_BNEL    = 6'd21;
   localparam logic [5:0] OP_BLEZL   = 6'd22;
   localparam logic [5:0] OP_BGTZL   = 6'd23;
   localparam logic [5:0] OP_DADDI   = 6'd24;
   localparam logic [5:0] OP_DADDIU  = 6'd25;

   // special funct codes
   localparam logic [5:0] FN_SLL    = 6'd0;
   localparam logic [5:0] FN_SRL    = 6'd2;
   localparam logic [5:0] FN_SRA    = 6'd3;
   localparam logic [5:0] FN_SLLV   = 6'd4;
   localparam logic [5:0] FN_SRLV   = 6'd6;
   localparam logic [5:0] FN_SRAV   = 6'd7;
   localparam logic [5:0] FN_JR     = 6'd8;
   localparam logic [5:0] FN_JALR   = 6'd9;
   localparam logic [5:0] FN_SYNC   = 6'd15;
   localparam logic [5:0] FN_MFHI   = 6'd16;
   localparam logic [5:0] FN_MTHI   = 6'd17;
   localparam logic [5:0] FN_MFLO   = 6'd18;
   localparam logic [5:0] FN_MTLO   = 6'd19;
   localparam logic [5:0] FN_DSLLV  = 6'd20;
   localparam logic [5:0] FN_MULT   = 6'd24;
   localparam logic [5:0] FN_MULTU  = 6'd25;
   localparam logic [5:0] FN_DIV    = 6'd26;
   localparam logic [5:0] FN_DIVU   = 6'd27;
   localparam logic [5:0] FN_DMULTU = 6'd29;
   localparam logic [5:0] FN_DDIV   = 6'd30;
   localparam logic [5:0] FN_DDIVU  = 6'd31;
   localparam logic [5:0] FN_ADD    = 6'd32;
   localparam logic [5:0] FN_ADDU   = 6'd33;
   localparam logic [5:0] FN_SUB    = 6'd34;
   localparam logic [5:0] FN_SUBU   = 6'd35;
   localparam logic [5:0] FN_AND    = 6'd36;
   localparam logic [5:0] FN_OR     = 6'd37;
   localparam logic [5:0] FN_XOR    = 6'd38;
   localparam logic [5:0] FN_NOR    = 6'd39;
   localparam logic [5:0] FN_SLT    = 6'd42;
   localparam logic [5:0] FN_SLTU   = 6'd43;
   localparam logic [5:0] FN_DSLL   = 6'd56;
   localparam logic [5:0] FN_DSRL   = 6'd58;
   localparam logic [5:0] FN_DSLL32 = 6'd60;
   localparam logic [5:0] FN_DSRL32 = 6'd62;
   localparam logic [5:0] FN_DSRA32 = 6'd63;

   // regimm rt codes
   localparam logic [4:0] RI_BLTZ   = 5'd0;
   localparam logic [4:0] RI_BGEZ   = 5'd1;
   localparam logic [4:0] RI_BLTZL  = 5'd2;
   localparam logic [4:0] RI_BGEZL  = 5'd3;
   localparam logic [4:0] RI_BGEZAL = 5'd17;

   localparam logic [63:0] JUMP_MASK = 64'hFFFF_FFFF_F000_0000;
   localparam logic [4:0]  LINK_REG  = 5'd31;

   // classification from the front end
   typedef enum logic [2:0] {
      CL_SIMPLE = 3'd0,  // ALU, branch or jump
      CL_MULT   = 3'd1,  // MULT / MULTU
      CL_DMULTU = 3'd2,
      CL_DIV32  = 3'd3,  // DIV / DIVU
      CL_DIV64  = 3'd4,  // DDIV / DDIVU
      CL_NONE   = 3'd5   // unimplemented opcode
   } class_type;

   typedef struct packed {
      req_type   req;
      class_type cls;
   } queue_entry_type;

   function automatic logic [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

endpackage

// ----- rtl/mips64_integer_execute.sv -----
// mips64_integer_execute: top level of the MIPS64 integer execute block.
// Depends on mxe_pkg, mxe_front, mxe_back (which holds mxe_muldiv).
//
// Usage:
//  - req channel: one item = instruction word plus its pc. Accepted on a
//    rising edge with req_valid high and req_stall low.
//  - rsp channel: one item per instruction, in order: register write-back,
//    branch redirect, annul flag and unimplemented flag.
//  - The front end classifies each item into a two-entry queue; the back end
//    reads the register file, executes and registers the result.
//  - ALU, branch and jump items are registered in a queue slot and then in
//    the rsp register; every multiply runs four partial products, divides
//    one quotient bit per cycle in the shared restoring divider. Throughput
//    for simple items is one per cycle when the receiver does not stall.
//  - A stalled rsp item holds; the back end stops at its next item and the
//    queue fills, after which req_stall rises.
//  - Reset clears the queue, HI, LO and the register valid bits, so every
//    general register reads as zero until written.
module mips64_integer_execute import mxe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic            q_valid, q_pop;
   queue_entry_type q_head;

   mxe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_head    (q_head)
   );

   mxe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // no write-back to r0 ever leaves the block
   a_no_r0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.wb_enable && rsp_data.wb_index == 5'd0))
      else $error("write-back to r0");

   // an unimplemented item carries no other effect
   a_unimp_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.unimplemented) |->
         (!rsp_data.wb_enable && !rsp_data.branch_taken && !rsp_data.annul_slot))
      else $error("unimplemented item with side effects");

   // taken and annul never together
   a_taken_annul: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.branch_taken && rsp_data.annul_slot))
      else $error("taken branch annulled its slot");

endmodule

// ----- rtl/mxe_front.sv -----
// mxe_front: accepts instruction items, classifies them and pushes them into
// a two-entry queue toward the back end. Depends on mxe_pkg.
module mxe_front import mxe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   output logic            q_valid,
   input  logic            q_pop,
   output queue_entry_type q_head
);

   queue_entry_type slot_ff [2];
   logic [1:0]      count_ff, count_in;
   logic            rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic            push, pop;
   class_type       cls;
   logic [5:0]      op, fn;
   logic [4:0]      rt;

   assign op = req_data.instr[31:26];
   assign fn = req_data.instr[5:0];
   assign rt = req_data.instr[20:16];

   always_comb begin
      cls = CL_SIMPLE;
      case (op)
         OP_SPECIAL: begin
            case (fn)
               FN_MULT, FN_MULTU: cls = CL_MULT;
               FN_DMULTU:         cls = CL_DMULTU;
               FN_DIV, FN_DIVU:   cls = CL_DIV32;
               FN_DDIV, FN_DDIVU: cls = CL_DIV64;
               FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
               FN_SYNC, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_DSLLV, FN_ADD,
               FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT,
               FN_SLTU, FN_DSLL, FN_DSRL, FN_DSLL32, FN_DSRL32, FN_DSRA32:
                  cls = CL_SIMPLE;
               default: cls = CL_NONE;
            endcase
         end
         OP_REGIMM: begin
            case (rt)
               RI_BLTZ, RI_BGEZ, RI_BLTZL, RI_BGEZL, RI_BGEZAL: cls = CL_SIMPLE;
               default: cls = CL_NONE;
            endcase
         end
         OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU,
         OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_BEQL, OP_BNEL,
         OP_BLEZL, OP_BGTZL, OP_DADDI, OP_DADDIU: cls = CL_SIMPLE;
         default: cls = CL_NONE;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;
   assign q_valid   = (count_ff != 2'd0);
   assign q_head    = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{req: req_data, cls: cls};
      end
   end

endmodule

// ----- rtl/mxe_muldiv.sv -----
// mxe_muldiv: multi-cycle multiply (32x32 partial products) and
// radix-2 restoring divider for HI/LO. Depends on mxe_pkg.
module mxe_muldiv import mxe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  class_type   cls,
   input  logic        is_unsigned,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic        write_hilo,
   output logic [63:0] hi_out,
   output logic [63:0] lo_out
);

   typedef enum logic [3:0] {
      MD_IDLE = 4'b0001,
      MD_MUL  = 4'b0010,
      MD_DIV  = 4'b0100,
      MD_DONE = 4'b1000
   } md_state_type;

   md_state_type state_ff, state_in;
   logic [2:0]   step_ff, step_in;     // multiply partial-product step
   logic [6:0]   bit_ff, bit_in;       // divide bits remaining
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic         wide_ff, wide_in, neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic         ok_ff, ok_in;
   logic         div_ff, div_in;
   logic [63:0]  pp_ff;
   logic [31:0]  mul_x, mul_y;
   logic [64:0]  trial;
   logic [64:0]  rem_sh;
   logic [63:0]  q_fix, r_fix;
   logic [63:0]  sa, sb;

   always_comb begin
      case (step_ff)
         3'd0:    begin mul_x = a_ff[31:0];  mul_y = b_ff[31:0];  end
         3'd1:    begin mul_x = a_ff[31:0];  mul_y = b_ff[63:32]; end
         3'd2:    begin mul_x = a_ff[63:32]; mul_y = b_ff[31:0];  end
         default: begin mul_x = a_ff[63:32]; mul_y = b_ff[63:32]; end
      endcase
   end

   // partial remainder keeps its top bit: divisors can reach 2^64 - 1
   assign rem_sh = {rem_ff, quo_ff[63]};
   assign trial  = rem_sh - {1'b0, b_ff};
   assign q_fix  = neg_q_ff ? (64'd0 - quo_ff) : quo_ff;
   assign r_fix  = neg_r_ff ? (64'd0 - rem_ff) : rem_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bit_in   = bit_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      wide_in  = wide_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      ok_in    = ok_ff;
      div_in   = div_ff;
      sa       = op_a;
      sb       = op_b;
      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               acc_in  = '0;
               step_in = 3'd0;
               wide_in = (cls == CL_DMULTU) || (cls == CL_DIV64);
               if (cls == CL_MULT || cls == CL_DIV32) begin
                  sa = is_unsigned ? {32'd0, op_a[31:0]} : sx32(op_a[31:0]);
                  sb = is_unsigned ? {32'd0, op_b[31:0]} : sx32(op_b[31:0]);
               end
               if (cls == CL_MULT || cls == CL_DMULTU) begin
                  a_in     = sa;
                  b_in     = sb;
                  div_in   = 1'b0;
                  state_in = MD_MUL;
               end else begin
                  neg_q_in = !is_unsigned && (sa[63] != sb[63]);
                  neg_r_in = !is_unsigned && sa[63];
                  quo_in   = (!is_unsigned && sa[63]) ? 64'd0 - sa : sa;
                  b_in     = (!is_unsigned && sb[63]) ? 64'd0 - sb : sb;
                  rem_in   = '0;
                  ok_in    = (sb != 64'd0);
                  bit_in   = 7'd64;
                  div_in   = 1'b1;
                  state_in = MD_DIV;
               end
            end
         end
         MD_MUL: begin
            // product of the previous step is registered, accumulate it
            step_in = step_ff + 3'd1;
            if (step_ff != 3'd0) begin
               case (step_ff)
                  3'd1:    acc_in = acc_ff + {64'd0, pp_ff};
                  3'd2:    acc_in = acc_ff + {32'd0, pp_ff, 32'd0};
                  3'd3:    acc_in = acc_ff + {32'd0, pp_ff, 32'd0};
                  default: acc_in = acc_ff + {pp_ff, 64'd0};
               endcase
            end
            // all four steps also for MULT: the sign-extended operands
            // need the cross terms in the low 64 bits
            if (step_ff == 3'd4) begin
               state_in = MD_DONE;
               ok_in    = 1'b1;
            end
         end
         MD_DIV: begin
            quo_in = {quo_ff[62:0], !trial[64]};
            rem_in = trial[64] ? rem_sh[63:0] : trial[63:0];
            bit_in = bit_ff - 7'd1;
            if (bit_ff == 7'd1) begin
               state_in = MD_DONE;
            end
         end
         MD_DONE: state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff  <= step_in;
      bit_ff   <= bit_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      wide_ff  <= wide_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      ok_ff    <= ok_in;
      div_ff   <= div_in;
      pp_ff    <= {32'd0, mul_x} * {32'd0, mul_y};
   end

   // 32-bit forms: low and high words of the result, sign-extended
   always_comb begin
      done       = (state_ff == MD_DONE);
      write_hilo = done && ok_ff;
      if (div_ff) begin
         lo_out = wide_ff ? q_fix : sx32(q_fix[31:0]);
         hi_out = wide_ff ? r_fix : sx32(r_fix[31:0]);
      end else if (wide_ff) begin
         lo_out = acc_ff[63:0];
         hi_out = acc_ff[127:64];
      end else begin
         lo_out = sx32(acc_ff[31:0]);
         hi_out = sx32(acc_ff[63:32]);
      end
   end

endmodule

// ----- rtl/mxe_back.sv -----
// mxe_back: register file, HI/LO, ALU and branch unit; runs
// multiply/divide through mxe_muldiv. Depends on mxe_pkg, mxe_muldiv.
module mxe_back import mxe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_pop,
   input  queue_entry_type q_head,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

   typedef enum logic [2:0] {
      BK_ISSUE = 3'b001,
      BK_WAIT  = 3'b010,
      BK_MD    = 3'b100
   } bk_state_type;

   bk_state_type state_ff, state_in;
   logic [63:0] gpr_ff [32];
   logic [31:0] gvalid_ff;   // entry not yet written reads as zero
   logic [63:0] hi_ff, lo_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, res;
   logic        gwen;
   logic [63:0] hi_in, lo_in;
   logic        hi_we, lo_we;

   logic [31:0] instr;
   logic [63:0] pc, a, b, imm_s, imm_z, link, btgt, val;
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sa, widx;
   logic        wen, lez, neg, cond, likely, isbr;
   logic        md_start, md_done, md_we;
   logic [63:0] md_hi, md_lo;
   logic        out_free;

   assign instr = q_head.req.instr;
   assign pc    = q_head.req.pc;
   assign op    = instr[31:26];
   assign fn    = instr[5:0];
   assign rs    = instr[25:21];
   assign rt    = instr[20:16];
   assign rd    = instr[15:11];
   assign sa    = instr[10:6];
   assign a     = gvalid_ff[rs] ? gpr_ff[rs] : 64'd0;
   assign b     = gvalid_ff[rt] ? gpr_ff[rt] : 64'd0;
   assign imm_s = {{48{instr[15]}}, instr[15:0]};
   assign imm_z = {48'd0, instr[15:0]};
   assign link  = pc + 64'd8;
   assign btgt  = pc + 64'd4 + {imm_s[61:0], 2'b00};
   assign lez   = a[63] || (a == 64'd0);
   assign neg   = a[63];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      wen    = 1'b0;
      widx   = rd;
      val    = '0;
      isbr   = 1'b0;
      cond   = 1'b0;
      likely = 1'b0;
      hi_we  = 1'b0;
      lo_we  = 1'b0;
      hi_in  = a;
      lo_in  = a;
      res    = '0;
      case (op)
         OP_SPECIAL: begin
            wen = 1'b1;
            case (fn)
               FN_SLL:  val = sx32(b[31:0] << sa);
               FN_SRL:  val = sx32(b[31:0] >> sa);
               FN_SRA:  val = 64'($signed(sx32(b[31:0])) >>> sa);
               FN_SLLV: val = sx32(b[31:0] << a[4:0]);
               FN_SRLV: val = sx32(b[31:0] >> a[4:0]);
               FN_SRAV: val = 64'($signed(sx32(b[31:0])) >>> a[4:0]);
               FN_JR:   begin wen = 1'b0; res.branch_taken = 1'b1;
                              res.branch_target = a; end
               FN_JALR: begin val = link; res.branch_taken = 1'b1;
                              res.branch_target = a; end
               FN_MFHI: val = hi_ff;
               FN_MTHI: begin wen = 1'b0; hi_we = 1'b1; end
               FN_MFLO: val = lo_ff;
               FN_MTLO: begin wen = 1'b0; lo_we = 1'b1; end
               FN_DSLLV: val = b << a[5:0];
               FN_ADD, FN_ADDU: val = sx32(a[31:0] + b[31:0]);
               FN_SUB, FN_SUBU: val = sx32(a[31:0] - b[31:0]);
               FN_AND:  val = a & b;
               FN_OR:   val = a | b;
               FN_XOR:  val = a ^ b;
               FN_NOR:  val = ~(a | b);
               FN_SLT:  val = {63'd0, $signed(a) < $signed(b)};
               FN_SLTU: val = {63'd0, a < b};
               FN_DSLL: val = b << sa;
               FN_DSRL: val = b >> sa;
               FN_DSLL32: val = b << ({1'b0, sa} + 6'd32);
               FN_DSRL32: val = b >> ({1'b0, sa} + 6'd32);
               FN_DSRA32: val = 64'($signed(b) >>> ({1'b0, sa} + 6'd32));
               default: wen = 1'b0;
            endcase
         end
         OP_REGIMM: begin
            isbr = 1'b1;
            case (rt)
               RI_BLTZ:   cond = neg;
               RI_BGEZ:   cond = !neg;
               RI_BLTZL:  begin cond = neg;  likely = 1'b1; end
               RI_BGEZL:  begin cond = !neg; likely = 1'b1; end
               RI_BGEZAL: begin cond = !neg; wen = 1'b1; widx = LINK_REG;
                                val = link; end
               default:   isbr = 1'b0;
            endcase
         end
         OP_J: begin res.branch_taken = 1'b1;
                     res.branch_target = (pc & JUMP_MASK) | {36'd0, instr[25:0], 2'b00}; end
         OP_JAL: begin res.branch_taken = 1'b1;
                     res.branch_target = (pc & JUMP_MASK) | {36'd0, instr[25:0], 2'b00};
                     wen = 1'b1; widx = LINK_REG; val = link; end
         OP_BEQ:   begin isbr = 1'b1; cond = (a == b); end
         OP_BNE:   begin isbr = 1'b1; cond = (a != b); end
         OP_BLEZ:  begin isbr = 1'b1; cond = lez; end
         OP_BGTZ:  begin isbr = 1'b1; cond = !lez; end
         OP_BEQL:  begin isbr = 1'b1; cond = (a == b); likely = 1'b1; end
         OP_BNEL:  begin isbr = 1'b1; cond = (a != b); likely = 1'b1; end
         OP_BLEZL: begin isbr = 1'b1; cond = lez; likely = 1'b1; end
         OP_BGTZL: begin isbr = 1'b1; cond = !lez; likely = 1'b1; end
         OP_ADDI, OP_ADDIU: begin wen = 1'b1; widx = rt; val = sx32(a[31:0] + imm_s[31:0]); end
         OP_SLTI:  begin wen = 1'b1; widx = rt; val = {63'd0, $signed(a) < $signed(imm_s)}; end
         OP_SLTIU: begin wen = 1'b1; widx = rt; val = {63'd0, a < imm_s}; end
         OP_ANDI:  begin wen = 1'b1; widx = rt; val = a & imm_z; end
         OP_ORI:   begin wen = 1'b1; widx = rt; val = a | imm_z; end
         OP_XORI:  begin wen = 1'b1; widx = rt; val = a ^ imm_z; end
         OP_LUI:   begin wen = 1'b1; widx = rt; val = sx32({instr[15:0], 16'd0}); end
         OP_DADDI, OP_DADDIU: begin wen = 1'b1; widx = rt; val = a + imm_s; end
         default: ;
      endcase
      if (isbr) begin
         res.branch_taken  = cond;
         res.branch_target = cond ? btgt : 64'd0;
         res.annul_slot    = !cond && likely;
      end
      if (q_head.cls != CL_SIMPLE) begin
         wen = 1'b0;
         hi_we = 1'b0;
         lo_we = 1'b0;
         res = '0;
      end
      res.unimplemented = (q_head.cls == CL_NONE);
      if (wen && widx != 5'd0) begin
         res.wb_enable = 1'b1;
         res.wb_index  = widx;
         res.wb_value  = val;
      end
   end

   assign gwen     = (state_ff == BK_ISSUE) && q_valid && out_free &&
                     (q_head.cls == CL_SIMPLE || q_head.cls == CL_NONE);
   assign md_start = (state_ff == BK_ISSUE) && q_valid && out_free &&
                     !(q_head.cls == CL_SIMPLE || q_head.cls == CL_NONE);
   assign q_pop    = gwen || (state_ff == BK_MD && md_done);

   mxe_muldiv u_md (
      .clock       (clock),
      .reset       (reset),
      .start       (md_start),
      .cls         (q_head.cls),
      .is_unsigned (fn[0]),
      .op_a        (a),
      .op_b        (b),
      .done        (md_done),
      .write_hilo  (md_we),
      .hi_out      (md_hi),
      .lo_out      (md_lo)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_ISSUE: if (md_start) state_in = BK_MD;
         BK_MD:    if (md_done) state_in = BK_ISSUE;
         BK_WAIT:  state_in = BK_ISSUE;
         default:  state_in = BK_ISSUE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_ISSUE;
         gvalid_ff    <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (gwen) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= res;
            if (res.wb_enable) begin
               gvalid_ff[widx] <= 1'b1;
            end
            if (hi_we) hi_ff <= hi_in;
            if (lo_we) lo_ff <= lo_in;
         end
         if (state_ff == BK_MD && md_done) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= '0;
            if (md_we) begin
               hi_ff <= md_hi;
               lo_ff <= md_lo;
            end
         end
      end
      if (gwen && res.wb_enable) begin
         gpr_ff[widx] <= val;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
